// ----- rtl/rth_pkg.sv -----
// ----------------------------------------------------------------------------
// rth_pkg
// Shared constants and types for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rth_pkg;

    // Default channel width and number of fractional hue bits.
    localparam int CHANNEL_BITS_DEFAULT  = 8;
    localparam int HUE_FRAC_BITS_DEFAULT = 6;

    // One colour sector spans this many whole degrees; a full turn has six.
    localparam int SECTOR_DEGREES = 60;
    localparam int SECTOR_COUNT   = 6;

    // Whole degree bits of the hue field (0 to 359).
    localparam int HUE_INT_BITS = 9;

    // Bits needed for one sector in fixed point, less the fractional bits.
    localparam int SECTOR_INT_BITS = 6;

    // Which channel is the largest, and so which sector formula applies.
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } hue_sel_t;

endpackage

// ----- rtl/rth_divider.sv -----
// ----------------------------------------------------------------------------
// rth_divider
// Pipelined restoring divider: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rth_divider #(
    parameter int DEN_BITS = 8,
    parameter int Q_BITS   = 12,
    parameter int REM_BITS = DEN_BITS + Q_BITS
) (
    input  logic                clk,
    input  logic                en,
    input  logic [REM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic [Q_BITS-1:0]   quo
);

    // The numerator must stay below den shifted left by Q_BITS.
    logic [REM_BITS-1:0] rem_reg [Q_BITS];
    logic [DEN_BITS-1:0] den_reg [Q_BITS];
    logic [Q_BITS-1:0]   quo_reg [Q_BITS];

    for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
        logic [REM_BITS-1:0] rem_in;
        logic [DEN_BITS-1:0] den_in;
        logic [Q_BITS-1:0]   quo_in;
        logic [REM_BITS-1:0] trial;
        logic                fits;
        logic [REM_BITS-1:0] rem_next;
        logic [Q_BITS-1:0]   quo_next;

        // Operands come from the ports on the first stage, else from the one before.
        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // Try to take the shifted divisor away from the partial remainder.
        always_comb
        begin
            trial    = REM_BITS'(den_in) << (Q_BITS - 1 - k);
            fits     = (rem_in >= trial);
            rem_next = fits ? (rem_in - trial) : rem_in;
            quo_next = {quo_in[Q_BITS-2:0], fits};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[Q_BITS-1];

endmodule

// ----- rtl/rgb_to_hsv_converter.sv -----
// Path: an accepted input passes the stage 1 and stage 2 registers, then Q
// = max(6 + HUE_FRAC_BITS, CHANNEL_BITS) divider stages, then the output register.
// Throughput: one pixel per cycle; the whole pipeline advances together and
// holds while a result waits at the output register.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Streaming RGB to HSV pixel converter with hue in fixed-point degrees.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS  = rth_pkg::CHANNEL_BITS_DEFAULT,
    parameter int HUE_FRAC_BITS = rth_pkg::HUE_FRAC_BITS_DEFAULT,
    parameter int IN_BITS       = ((3 * CHANNEL_BITS + 7) / 8) * 8,
    parameter int OUT_BITS      =
        ((rth_pkg::HUE_INT_BITS + HUE_FRAC_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    output logic                s_tready,
    // Fields from bit 0: red_in, green_in, blue_in, zero padding.
    input  logic [IN_BITS-1:0]  s_tdata,

    output logic                m_tvalid,
    input  logic                m_tready,
    // Fields from bit 0: hue_out, saturation_out, value_out, zero padding.
    output logic [OUT_BITS-1:0] m_tdata
);

    localparam int CB        = CHANNEL_BITS;
    localparam int HUE_BITS  = rth_pkg::HUE_INT_BITS + HUE_FRAC_BITS;
    localparam int SQ_BITS   = rth_pkg::SECTOR_INT_BITS + HUE_FRAC_BITS;
    localparam int QW        = (SQ_BITS > CB) ? SQ_BITS : CB;
    localparam int RW        = CB + QW;
    localparam int SECTOR    = rth_pkg::SECTOR_DEGREES << HUE_FRAC_BITS;
    localparam int CMAX      = (1 << CB) - 1;
    localparam int OUT_PAD   = OUT_BITS - HUE_BITS - 2 * CB;

    localparam logic [HUE_BITS-1:0] HUE_GREEN = HUE_BITS'(2 * SECTOR);
    localparam logic [HUE_BITS-1:0] HUE_BLUE  = HUE_BITS'(4 * SECTOR);
    localparam logic [HUE_BITS-1:0] HUE_TURN  =
        HUE_BITS'(rth_pkg::SECTOR_COUNT * SECTOR);

    // The whole pipeline moves when the output register is free or being emptied.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // Stage 1: largest and smallest channel, sector choice and difference.
    // ------------------------------------------------------------------
    logic [CB-1:0]     red, green, blue;
    logic [CB-1:0]     mx, mn, op_a, op_b;
    rth_pkg::hue_sel_t sel;

    assign red   = s_tdata[CB-1:0];
    assign green = s_tdata[2*CB-1:CB];
    assign blue  = s_tdata[3*CB-1:2*CB];

    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            sel  = rth_pkg::SEL_RED;
            mx   = red;
            op_a = green;
            op_b = blue;
        end
        else if (green >= blue)
        begin
            sel  = rth_pkg::SEL_GREEN;
            mx   = green;
            op_a = blue;
            op_b = red;
        end
        else
        begin
            sel  = rth_pkg::SEL_BLUE;
            mx   = blue;
            op_a = red;
            op_b = green;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
    end

    logic              v1_reg;
    logic [CB-1:0]     mx1_reg, delta1_reg, abs1_reg;
    logic              neg1_reg;
    rth_pkg::hue_sel_t sel1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx1_reg    <= mx;
            delta1_reg <= mx - mn;
            neg1_reg   <= (op_a < op_b);
            abs1_reg   <= (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
            sel1_reg   <= sel;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale the dividends by one sector and by full scale.
    // ------------------------------------------------------------------
    logic              v2_reg;
    logic [RW-1:0]     numh2_reg, nums2_reg;
    logic [CB-1:0]     mx2_reg, delta2_reg;
    logic              neg2_reg, zero2_reg;
    rth_pkg::hue_sel_t sel2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            numh2_reg  <= RW'(abs1_reg) * RW'(SECTOR);
            nums2_reg  <= RW'(delta1_reg) * RW'(CMAX);
            mx2_reg    <= mx1_reg;
            delta2_reg <= delta1_reg;
            neg2_reg   <= neg1_reg;
            zero2_reg  <= (delta1_reg == '0);
            sel2_reg   <= sel1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: hue part over delta, saturation over the maximum.
    // ------------------------------------------------------------------
    logic [QW-1:0] quo_h, quo_s;

    rth_divider #(
        .DEN_BITS (CB),
        .Q_BITS   (QW),
        .REM_BITS (RW)
    ) u_div_hue (
        .clk (clk),
        .en  (adv),
        .num (numh2_reg),
        .den (delta2_reg),
        .quo (quo_h)
    );

    rth_divider #(
        .DEN_BITS (CB),
        .Q_BITS   (QW),
        .REM_BITS (RW)
    ) u_div_sat (
        .clk (clk),
        .en  (adv),
        .num (nums2_reg),
        .den (mx2_reg),
        .quo (quo_s)
    );

    // Side information travels alongside the divider stages.
    logic              vd_reg   [QW];
    logic [CB-1:0]     mxd_reg  [QW];
    logic              negd_reg [QW];
    logic              zerod_reg[QW];
    rth_pkg::hue_sel_t seld_reg [QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                vd_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vd_reg[0] <= v2_reg;
            for (int k = 1; k < QW; k++)
            begin
                vd_reg[k] <= vd_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mxd_reg[0]   <= mx2_reg;
            negd_reg[0]  <= neg2_reg;
            zerod_reg[0] <= zero2_reg;
            seld_reg[0]  <= sel2_reg;
            for (int k = 1; k < QW; k++)
            begin
                mxd_reg[k]   <= mxd_reg[k-1];
                negd_reg[k]  <= negd_reg[k-1];
                zerod_reg[k] <= zerod_reg[k-1];
                seld_reg[k]  <= seld_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage: place the signed sector part onto its sector offset.
    // ------------------------------------------------------------------
    logic [HUE_BITS-1:0] q_part, hue_base, hue_next;
    logic [CB-1:0]       sat_next;

    always_comb
    begin
        q_part = HUE_BITS'(quo_h[SQ_BITS-1:0]);
        case (seld_reg[QW-1])
            rth_pkg::SEL_RED:
            begin
                // A negative red part wraps round a full turn, unless it truncated to zero.
                hue_base = (negd_reg[QW-1] && q_part != '0) ? HUE_TURN : '0;
            end
            rth_pkg::SEL_GREEN:
            begin
                hue_base = HUE_GREEN;
            end
            rth_pkg::SEL_BLUE:
            begin
                hue_base = HUE_BLUE;
            end
            default:
            begin
                hue_base = '0;
            end
        endcase
        hue_next = negd_reg[QW-1] ? (hue_base - q_part) : (hue_base + q_part);
        sat_next = quo_s[CB-1:0];
        // A grey pixel has neither hue nor saturation.
        if (zerod_reg[QW-1])
        begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    logic                out_valid_reg;
    logic [HUE_BITS-1:0] hue_reg;
    logic [CB-1:0]       sat_reg, val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vd_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= mxd_reg[QW-1];
        end
    end

    assign m_tvalid = out_valid_reg;

    if (OUT_PAD > 0) begin : g_pad
        assign m_tdata = {{OUT_PAD{1'b0}}, val_reg, sat_reg, hue_reg};
    end
    else begin : g_nopad
        assign m_tdata = {val_reg, sat_reg, hue_reg};
    end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming RGB to HSV converter. Pixels are
// sent through the slave stream. Each accepted pixel is run through a
// behavioural model of the conversion, and the model's result is queued.
// Each result leaving the master stream is compared field by field with the
// oldest queued result. Both sides idle at random, and at one point the
// receiver holds off long enough for the pipeline to fill and stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int CHAN_BITS  = rth_pkg::CHANNEL_BITS_DEFAULT;
    localparam int FRAC_BITS  = rth_pkg::HUE_FRAC_BITS_DEFAULT;
    localparam int HUE_BITS   = rth_pkg::HUE_INT_BITS + FRAC_BITS;
    localparam int PIX_BITS   = ((3 * CHAN_BITS + 7) / 8) * 8;
    localparam int HSV_BITS   = ((HUE_BITS + 2 * CHAN_BITS + 7) / 8) * 8;
    localparam int FULL_SCALE = (1 << CHAN_BITS) - 1;
    localparam int SECTOR     = rth_pkg::SECTOR_DEGREES << FRAC_BITS;
    localparam int FULL_TURN  = rth_pkg::SECTOR_COUNT * SECTOR;
    localparam int PAD_BITS   = HSV_BITS - HUE_BITS - 2 * CHAN_BITS;
    localparam int SQ_BITS    = rth_pkg::SECTOR_INT_BITS + FRAC_BITS;

    localparam int PIPE_LATENCY    = ((SQ_BITS > CHAN_BITS) ? SQ_BITS : CHAN_BITS) + 3;
    localparam int ITEMS_PER_PHASE = 217;
    localparam int HOLD_CYCLES     = 80;

    typedef struct packed {
        logic [CHAN_BITS-1:0] value;
        logic [CHAN_BITS-1:0] saturation;
        logic [HUE_BITS-1:0]  hue;
    } hsv_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts HSV for each accepted pixel and checks results.
    // ------------------------------------------------------------------------
    class hsv_scoreboard;
        hsv_t expected_hsv_q[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        // Integer model of the conversion; division truncates toward zero.
        function hsv_t convert_pixel(logic [CHAN_BITS-1:0] r, logic [CHAN_BITS-1:0] g,
                                     logic [CHAN_BITS-1:0] b);
            int                rv, gv, bv, top, bottom, delta, hue, sat;
            rth_pkg::hue_sel_t sel;
            hsv_t              res;
            rv = r;
            gv = g;
            bv = b;
            top = rv;
            bottom = rv;
            sel = rth_pkg::SEL_RED;
            if (gv > top)
            begin
                top = gv;
                sel = rth_pkg::SEL_GREEN;
            end
            if (bv > top)
            begin
                top = bv;
                sel = rth_pkg::SEL_BLUE;
            end
            if (gv < bottom) bottom = gv;
            if (bv < bottom) bottom = bv;
            delta = top - bottom;
            hue = 0;
            sat = 0;
            if (delta > 0)
            begin
                case (sel)
                    rth_pkg::SEL_RED:
                    begin
                        hue = (SECTOR * (gv - bv)) / delta;
                        if (hue < 0) hue = hue + FULL_TURN;
                    end
                    rth_pkg::SEL_GREEN: hue = 2 * SECTOR + (SECTOR * (bv - rv)) / delta;
                    default:            hue = 4 * SECTOR + (SECTOR * (rv - gv)) / delta;
                endcase
                sat = (FULL_SCALE * delta) / top;
            end
            res.hue        = hue[HUE_BITS-1:0];
            res.saturation = sat[CHAN_BITS-1:0];
            res.value      = top[CHAN_BITS-1:0];
            return res;
        endfunction

        // Notes a pixel accepted on the slave side.
        function void note_pixel(logic [PIX_BITS-1:0] px);
            expected_hsv_q.push_back(convert_pixel(px[CHAN_BITS-1:0],
                                                   px[2*CHAN_BITS-1:CHAN_BITS],
                                                   px[3*CHAN_BITS-1:2*CHAN_BITS]));
        endfunction

        // Compares a result accepted on the master side with the oldest prediction.
        function void check_result(logic [HSV_BITS-1:0] d);
            hsv_t exp_hsv;
            hsv_t got;
            if (expected_hsv_q.size() == 0)
            begin
                $display("%0t: unexpected result transaction, data %h", $time, d);
                errors++;
                return;
            end
            exp_hsv = expected_hsv_q.pop_front();
            got = d[HUE_BITS+2*CHAN_BITS-1:0];
            if (got.hue !== exp_hsv.hue)
            begin
                $display("%0t: hue expected %0d actual %0d", $time, exp_hsv.hue, got.hue);
                errors++;
            end
            if (got.saturation !== exp_hsv.saturation)
            begin
                $display("%0t: saturation expected %0d actual %0d", $time,
                         exp_hsv.saturation, got.saturation);
                errors++;
            end
            if (got.value !== exp_hsv.value)
            begin
                $display("%0t: value expected %0d actual %0d", $time,
                         exp_hsv.value, got.value);
                errors++;
            end
            if (PAD_BITS > 0 && d[HSV_BITS-1:HUE_BITS+2*CHAN_BITS] !== '0)
            begin
                $display("%0t: padding expected 0 actual %h", $time,
                         d[HSV_BITS-1:HUE_BITS+2*CHAN_BITS]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_hsv_q.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [PIX_BITS-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [HSV_BITS-1:0] m_tdata;

    hsv_scoreboard sb;
    int            tx_idle_pct;
    int            rx_idle_pct;
    bit            hold_request;

    rgb_to_hsv_converter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Overall time limit for the run.
    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: random back-pressure, with one long hold-off on request.
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (!rst_n)
                m_tready <= 1'b0;
            else if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result monitor; signals are stable at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    function automatic logic [PIX_BITS-1:0] make_pixel(int r, int g, int b);
        logic [PIX_BITS-1:0] px;
        px = '0;
        px[CHAN_BITS-1:0]             = r[CHAN_BITS-1:0];
        px[2*CHAN_BITS-1:CHAN_BITS]   = g[CHAN_BITS-1:0];
        px[3*CHAN_BITS-1:2*CHAN_BITS] = b[CHAN_BITS-1:0];
        return px;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(3))
            0: return 0;
            1: return 1;
            2: return FULL_SCALE - 1;
            default: return FULL_SCALE;
        endcase
    endfunction

    // Random pixel mix: mostly uniform, plus grey, tied maxima, small deltas
    // and channels at the ends of their range.
    function automatic logic [PIX_BITS-1:0] random_pixel();
        int v, w, base;
        v = $urandom_range(FULL_SCALE);
        w = $urandom_range(FULL_SCALE);
        if (w > v)
        begin
            base = v;
            v = w;
            w = base;
        end
        case ($urandom_range(9))
            6: return make_pixel(v, v, v);
            7:
            begin
                case ($urandom_range(2))
                    0: return make_pixel(v, v, w);
                    1: return make_pixel(w, v, v);
                    default: return make_pixel(v, w, v);
                endcase
            end
            8:
            begin
                base = $urandom_range(FULL_SCALE - 2);
                return make_pixel(base + $urandom_range(2), base + $urandom_range(2),
                                  base + $urandom_range(2));
            end
            9: return make_pixel(pick_extreme(), pick_extreme(), pick_extreme());
            default: return PIX_BITS'($urandom);
        endcase
    endfunction

    // Random idle cycles on the slave side before the next pixel.
    task automatic sender_gap();
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Offers one pixel and returns at the edge where it is accepted.
    task automatic send_pixel(logic [PIX_BITS-1:0] px);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        sb.note_pixel(px);
    endtask

    // Main stimulus.
    initial
    begin
        logic [PIX_BITS-1:0] directed_q[$];
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        tx_idle_pct = 27;
        rx_idle_pct = 57;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels: black, white, greys, primaries, ties between
        // channels, negative red-sector hue that wraps, and minimal deltas.
        directed_q = '{make_pixel(0, 0, 0), make_pixel(255, 255, 255),
                       make_pixel(128, 128, 128), make_pixel(1, 1, 1),
                       make_pixel(255, 0, 0), make_pixel(0, 255, 0),
                       make_pixel(0, 0, 255), make_pixel(255, 255, 0),
                       make_pixel(0, 255, 255), make_pixel(255, 0, 255),
                       make_pixel(255, 0, 1), make_pixel(255, 0, 100),
                       make_pixel(255, 0, 254), make_pixel(1, 0, 0),
                       make_pixel(0, 1, 0), make_pixel(0, 0, 1),
                       make_pixel(100, 255, 50), make_pixel(50, 255, 100),
                       make_pixel(10, 20, 255), make_pixel(20, 10, 255),
                       make_pixel(255, 254, 254), make_pixel(254, 255, 254),
                       make_pixel(254, 254, 255), make_pixel(200, 10, 200)};
        foreach (directed_q[i])
        begin
            sender_gap();
            send_pixel(directed_q[i]);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 27;
                    rx_idle_pct = 57;
                end
                1:
                begin
                    tx_idle_pct = 57;
                    rx_idle_pct = 27;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // Long receiver stall while pixels keep coming.
                    hold_request = 1'b1;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
            begin
                sender_gap();
                send_pixel(random_pixel());
            end
        end
        s_tvalid <= 1'b0;

        // Drain the pipeline, then allow for anything still in flight.
        while (sb.pending() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 5) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- rgb_to_hsv_converter.f -----
rtl/rth_pkg.sv
rtl/rth_divider.sv
rtl/rgb_to_hsv_converter.sv
bench/tb.sv
